### rtl/wireless_frame_filter_deframer_core_assert.svh
// Assertion macros used by the RTL of the frame filter / deframer.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef WIRELESS_FRAME_FILTER_DEFRAMER_CORE_ASSERT_SVH
`define WIRELESS_FRAME_FILTER_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define WFFD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wffd: same-cycle check violated");

// next-cycle implication
`define WFFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wffd: next-cycle check violated");

`endif

### rtl/wffd_pkg.sv
// ----------------------------------------------------------------------------
// wffd_pkg
// Types and constants of the data-frame filter / deframer.
// ----------------------------------------------------------------------------
package wffd_pkg;

   localparam int POS_W            = 12;
   localparam int PSIZE_W          = 10;
   localparam int DEFAULT_MAX_PAYLOAD = 512;
   localparam int MIN_FRAME        = 48;

   // byte offsets within a frame
   localparam logic [POS_W-1:0] POS_FC0     = 12'd0;
   localparam logic [POS_W-1:0] POS_FC1     = 12'd1;
   localparam logic [POS_W-1:0] DEST_FIRST  = 12'd4;
   localparam logic [POS_W-1:0] DEST_LAST   = 12'd9;
   localparam logic [POS_W-1:0] BSSID_FIRST = 12'd16;
   localparam logic [POS_W-1:0] BSSID_LAST  = 12'd21;
   localparam logic [POS_W-1:0] MAGIC_FIRST = 12'd24;
   localparam logic [POS_W-1:0] MAGIC_LAST  = 12'd27;
   localparam logic [POS_W-1:0] POS_VER     = 12'd28;
   localparam logic [POS_W-1:0] POS_TYPE    = 12'd29;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 12'd30;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 12'd31;
   localparam logic [POS_W-1:0] SEQ_FIRST   = 12'd32;
   localparam logic [POS_W-1:0] SEQ_LAST    = 12'd35;
   localparam logic [POS_W-1:0] TS_FIRST    = 12'd36;
   localparam logic [POS_W-1:0] HDR_LAST    = 12'd43;
   localparam logic [POS_W-1:0] POS_MAX     = 12'd4095;

   localparam logic [7:0] FC0_BYTE   = 8'h08;
   localparam logic [7:0] FC1_BYTE   = 8'h00;
   localparam logic [7:0] BCAST_BYTE = 8'hff;

   // register indexes
   localparam logic [1:0] CSR_BSSID   = 2'd0;
   localparam logic [1:0] CSR_MAGIC   = 2'd1;
   localparam logic [1:0] CSR_VERSION = 2'd2;

   localparam logic [47:0] BSSID_RESET   = 48'h0242_4242_4242;
   localparam logic [31:0] MAGIC_RESET   = 32'h4242_5244;
   localparam logic [7:0]  VERSION_RESET = 8'h01;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_TRUNC   = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [47:0] bssid;
      logic [31:0] magic_word;
      logic [7:0]  protocol_version;
   } cfg_type;

   typedef struct packed {
      result_kind_type     kind;
      logic [7:0]          proto_type;
      logic [PSIZE_W-1:0]  payload_size;
      logic [31:0]         seq_num;
      logic [63:0]         sender_timestamp;
      logic signed [7:0]   signal_strength;
      logic [7:0]          payload_byte;
      logic                last;
   } rsp_type;

endpackage

### rtl/wffd_hdr_match.sv
// ----------------------------------------------------------------------------
// wffd_hdr_match
// Flags a received byte that differs from the expected header byte at its
// position. Positions without a fixed value never mismatch.
// ----------------------------------------------------------------------------
module wffd_hdr_match import wffd_pkg::*; (
   input  logic [POS_W-1:0] pos,
   input  logic [7:0]       rx_byte,
   input  cfg_type          cfg,
   output logic             mismatch
);

   logic [POS_W-1:0] bssid_off;
   logic [POS_W-1:0] magic_off;
   logic [7:0]       exp_byte;
   logic             check;

   always_comb begin
      // first received byte sits in the top bits
      bssid_off = BSSID_LAST - pos;
      magic_off = MAGIC_LAST - pos;
      check     = 1'b1;
      exp_byte  = 8'h00;
      priority if (pos == POS_FC0) begin
         exp_byte = FC0_BYTE;
      end else if (pos == POS_FC1) begin
         exp_byte = FC1_BYTE;
      end else if (pos >= DEST_FIRST && pos <= DEST_LAST) begin
         exp_byte = BCAST_BYTE;
      end else if (pos >= BSSID_FIRST && pos <= BSSID_LAST) begin
         exp_byte = cfg.bssid[{bssid_off[2:0], 3'b000} +: 8];
      end else if (pos >= MAGIC_FIRST && pos <= MAGIC_LAST) begin
         exp_byte = cfg.magic_word[{magic_off[1:0], 3'b000} +: 8];
      end else if (pos == POS_VER) begin
         exp_byte = cfg.protocol_version;
      end else begin
         check = 1'b0;
      end
      mismatch = check && (rx_byte != exp_byte);
   end

endmodule

### rtl/wffd_rsp_reg.sv
// ----------------------------------------------------------------------------
// wffd_rsp_reg
// Result register: holds one item until the consumer takes it.
// ----------------------------------------------------------------------------
module wffd_rsp_reg import wffd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    take,
   output logic    valid,
   output rsp_type data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

### rtl/wireless_frame_filter_deframer_core.sv
// ----------------------------------------------------------------------------
// wireless_frame_filter_deframer_core
// Filters received 802.11 data frames and splits off the protocol payload.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and sustains one item per clock.
// Each byte is checked and its header field captured in the cycle it is
// accepted; any result goes into a single result register. Input is stalled
// only while that register holds an item the consumer has not taken, so with
// rsp_tready high the throughput is one byte per cycle and a result appears
// in the cycle after the byte that causes it. A frame passes when it is a data
// frame of at least 48 bytes with frame control 08 00, broadcast destination
// and matching BSSID, magic word and version, and its payload length fits
// both the frame and MAX_PAYLOAD. Then byte 43 gives a header item (kind 0),
// each payload byte gives a payload item (kind 1), and the final one carries
// tlast. A new frame_start in the middle of a payload first gives a truncation
// item (kind 2, tlast set) with the old message's fields. Captured multi-byte
// header fields are little-endian. Registers are written through csr_*, always ready;
// write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module wireless_frame_filter_deframer_core import wffd_pkg::*; #(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic          clock,
   input  logic          reset,
   // input byte stream
   input  logic          req_tvalid,
   output logic          req_tready,
   // [7:0] frame_byte, [19:8] frame_len, [27:20] rssi, [31:28] zero
   input  logic [31:0]   req_tdata,
   // [0] frame_start, [1] is_data_frame
   input  logic [1:0]    req_tuser,
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [7:0] proto_type, [17:8] payload_size, [49:18] seq_num,
   // [113:50] sender_timestamp, [121:114] signal_strength,
   // [129:122] payload_byte, [135:130] zero
   output logic [135:0]  rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   // register writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [47:0]   csr_data
);

   `include "wireless_frame_filter_deframer_core_assert.svh"

   localparam int REMAIN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [15:0] MAX_PL = 16'(MAX_PAYLOAD);
   localparam logic [POS_W-1:0] MIN_LEN = POS_W'(MIN_FRAME);

   // input fields
   logic [7:0]       rx_byte;
   logic             rx_start;
   logic [POS_W-1:0] rx_len;
   logic signed [7:0] rx_rssi;
   logic             rx_is_data;

   assign rx_byte    = req_tdata[7:0];
   assign rx_len     = req_tdata[19:8];
   assign rx_rssi    = $signed(req_tdata[27:20]);
   assign rx_start   = req_tuser[0];
   assign rx_is_data = req_tuser[1];

   // configuration
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BSSID:   cfg_in.bssid            = csr_data;
            CSR_MAGIC:   cfg_in.magic_word       = csr_data[31:0];
            CSR_VERSION: cfg_in.protocol_version = csr_data[7:0];
            default:     cfg_in = cfg_ff;       // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bssid            <= BSSID_RESET;
         cfg_ff.magic_word       <= MAGIC_RESET;
         cfg_ff.protocol_version <= VERSION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // frame state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                good_ff, good_in;
   logic [REMAIN_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]    len_ff, len_in;
   logic [7:0]          type_ff, type_in;
   logic [15:0]         plen_ff, plen_in;
   logic [31:0]         seq_ff, seq_in;
   logic [63:0]         ts_ff, ts_in;
   logic signed [7:0]   rssi_ff, rssi_in;

   logic                accept;
   logic [POS_W-1:0]    pos_cur;
   logic                good_cur;
   logic [REMAIN_W-1:0] rem_cur;
   logic [POS_W-1:0]    seq_off;
   logic [POS_W-1:0]    ts_off;
   logic [15:0]         room;
   logic                mismatch;

   logic    rsp_load;
   rsp_type rsp_in;
   rsp_type rsp_q;
   logic    rsp_valid;

   assign req_tready = !rsp_valid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   wffd_hdr_match u_hdr_match (
      .pos      (pos_cur),
      .rx_byte  (rx_byte),
      .cfg      (cfg_ff),
      .mismatch (mismatch)
   );

   always_comb begin
      pos_cur  = rx_start ? '0 : pos_ff;
      good_cur = rx_start ? (rx_is_data && rx_len >= MIN_LEN) : good_ff;
      rem_cur  = rx_start ? '0 : rem_ff;
      seq_off  = pos_cur - SEQ_FIRST;
      ts_off   = pos_cur - TS_FIRST;

      pos_in  = pos_ff;
      good_in = good_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      type_in = type_ff;
      plen_in = plen_ff;
      seq_in  = seq_ff;
      ts_in   = ts_ff;
      rssi_in = rssi_ff;
      room    = '0;

      rsp_load = 1'b0;
      rsp_in   = '0;

      if (accept) begin
         // truncation item reports the old message before anything changes
         if (rx_start && good_ff && pos_ff > HDR_LAST && rem_ff != '0) begin
            rsp_load                = 1'b1;
            rsp_in.kind             = KIND_TRUNC;
            rsp_in.proto_type       = type_ff;
            rsp_in.payload_size     = plen_ff[PSIZE_W-1:0];
            rsp_in.seq_num          = seq_ff;
            rsp_in.sender_timestamp = ts_ff;
            rsp_in.signal_strength  = rssi_ff;
            rsp_in.payload_byte     = 8'h00;
            rsp_in.last             = 1'b1;
         end

         if (rx_start) begin
            len_in  = rx_len;
            rssi_in = rx_rssi;
         end
         good_in = good_cur;
         rem_in  = rem_cur;

         if (good_cur) begin
            if (mismatch) begin
               good_in = 1'b0;
            end
            // header field capture
            if (pos_cur == POS_TYPE) begin
               type_in = rx_byte;
            end
            if (pos_cur == POS_LEN_LO) begin
               plen_in[7:0] = rx_byte;
            end
            if (pos_cur == POS_LEN_HI) begin
               plen_in[15:8] = rx_byte;
            end
            if (pos_cur >= SEQ_FIRST && pos_cur <= SEQ_LAST) begin
               seq_in[{seq_off[1:0], 3'b000} +: 8] = rx_byte;
            end
            if (pos_cur >= TS_FIRST && pos_cur <= HDR_LAST) begin
               ts_in[{ts_off[2:0], 3'b000} +: 8] = rx_byte;
            end

            if (pos_cur == HDR_LAST) begin
               // frame length is at least 48 here, so no underflow
               room = {{(16-POS_W){1'b0}}, len_in - MIN_LEN};
               if (plen_in > room || plen_in > MAX_PL) begin
                  good_in = 1'b0;
               end else begin
                  rem_in                  = plen_in[REMAIN_W-1:0];
                  rsp_load                = 1'b1;
                  rsp_in.kind             = KIND_HEADER;
                  rsp_in.proto_type       = type_in;
                  rsp_in.payload_size     = plen_in[PSIZE_W-1:0];
                  rsp_in.seq_num          = seq_in;
                  rsp_in.sender_timestamp = ts_in;
                  rsp_in.signal_strength  = rssi_in;
                  rsp_in.payload_byte     = 8'h00;
                  rsp_in.last             = (plen_in == 16'd0);
               end
            end else if (pos_cur > HDR_LAST && rem_cur != '0) begin
               rsp_load                = 1'b1;
               rsp_in.kind             = KIND_PAYLOAD;
               rsp_in.proto_type       = type_ff;
               rsp_in.payload_size     = plen_ff[PSIZE_W-1:0];
               rsp_in.seq_num          = seq_ff;
               rsp_in.sender_timestamp = ts_ff;
               rsp_in.signal_strength  = rssi_ff;
               rsp_in.payload_byte     = rx_byte;
               rsp_in.last             = (rem_cur == REMAIN_W'(1));
               rem_in                  = rem_cur - REMAIN_W'(1);
            end
         end

         // position saturates so trailing bytes stay ignored
         pos_in = (pos_cur == POS_MAX) ? pos_cur : pos_cur + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         good_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         good_ff <= good_in;
         rem_ff  <= rem_in;
      end
   end

   // captured header fields; only read after their capture in the current frame
   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      type_ff <= type_in;
      plen_ff <= plen_in;
      seq_ff  <= seq_in;
      ts_ff   <= ts_in;
      rssi_ff <= rssi_in;
   end

   wffd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_in),
      .take      (rsp_tready),
      .valid     (rsp_valid),
      .data      (rsp_q)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp_q.kind;
   assign rsp_tlast  = rsp_q.last;
   assign rsp_tdata  = {6'b000000,
                        rsp_q.payload_byte,
                        rsp_q.signal_strength,
                        rsp_q.sender_timestamp,
                        rsp_q.seq_num,
                        rsp_q.payload_size,
                        rsp_q.proto_type};

   // a payload in progress belongs to a frame that passed its header
   `WFFD_ASSERT_HOLDS(a_rem_good, clock, reset, rem_ff != '0, good_ff)
   `WFFD_ASSERT_HOLDS(a_rem_pos, clock, reset, rem_ff != '0, pos_ff > HDR_LAST)
   `WFFD_ASSERT_HOLDS(a_rem_max, clock, reset, 1'b1, rem_ff <= MAX_PL[REMAIN_W-1:0])
   // truncation always closes a message
   `WFFD_ASSERT_HOLDS(a_trunc_last, clock, reset,
                      rsp_tvalid && rsp_tuser == KIND_TRUNC, rsp_tlast)
   // a frame start never leaves a payload pending
   `WFFD_ASSERT_NEXT(a_start_clears, clock, reset, accept && rx_start, rem_ff == '0)

endmodule

### verif/deframer_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_scoreboard_pkg
// Predicts the items of the data-frame filter / deframer and checks them.
// ----------------------------------------------------------------------------
package deframer_scoreboard_pkg;
   import wffd_pkg::*;

   localparam int PAYLOAD_LIMIT = DEFAULT_MAX_PAYLOAD;

   class deframer_scoreboard;
      // register copies
      logic [47:0]  bssid;
      logic [31:0]  magic;
      logic [7:0]   version;
      // frame state
      logic [11:0]  position;
      bit           good;
      logic [11:0]  length;
      logic [7:0]   msg_type;
      logic [15:0]  msg_len;
      logic [31:0]  msg_seq;
      logic [63:0]  msg_stamp;
      logic [7:0]   msg_rssi;
      int unsigned  remaining;

      rsp_type      deframed_queue[$];
      int           mismatches;
      int           bytes_in;
      int           kind_count[3];

      function new();
         bssid      = BSSID_RESET;
         magic      = MAGIC_RESET;
         version    = VERSION_RESET;
         position   = '0;
         good       = 1'b0;
         length     = '0;
         msg_type   = '0;
         msg_len    = '0;
         msg_seq    = '0;
         msg_stamp  = '0;
         msg_rssi   = '0;
         remaining  = 0;
         mismatches = 0;
         bytes_in   = 0;
         kind_count = '{0, 0, 0};
      endfunction

      function void write_reg(logic [1:0] index, logic [47:0] data);
         case (index)
            CSR_BSSID:   bssid   = data;
            CSR_MAGIC:   magic   = data[31:0];
            CSR_VERSION: version = data[7:0];
            default: ;
         endcase
      endfunction

      function void queue_result(result_kind_type kind, logic [7:0] pbyte, bit last);
         rsp_type r;
         r.kind             = kind;
         r.proto_type       = msg_type;
         r.payload_size     = msg_len[PSIZE_W-1:0];
         r.seq_num          = msg_seq;
         r.sender_timestamp = msg_stamp;
         r.signal_strength  = msg_rssi;
         r.payload_byte     = pbyte;
         r.last             = last;
         deframed_queue.push_back(r);
         kind_count[kind]++;
      endfunction

      // one accepted byte: advance the frame state, queue any item it causes
      function void deframe_byte(logic [7:0] b, bit start, logic [11:0] flen,
                                 logic [7:0] rssi, bit data);
         logic [11:0] p;
         bytes_in++;
         if (start) begin
            if (good && position > HDR_LAST && remaining > 0)
               queue_result(KIND_TRUNC, 8'h00, 1'b1);
            length    = flen;
            msg_rssi  = rssi;
            good      = data && (flen >= MIN_FRAME);
            remaining = 0;
            p         = '0;
         end else begin
            p = position;
         end

         if (good) begin
            if (p == POS_FC0)
               good = (b == FC0_BYTE);
            else if (p == POS_FC1)
               good = (b == FC1_BYTE);
            else if (p >= DEST_FIRST && p <= DEST_LAST)
               good = (b == BCAST_BYTE);
            else if (p >= BSSID_FIRST && p <= BSSID_LAST)
               good = (b == bssid[8*(BSSID_LAST - p) +: 8]);
            else if (p >= MAGIC_FIRST && p <= MAGIC_LAST)
               good = (b == magic[8*(MAGIC_LAST - p) +: 8]);
            else if (p == POS_VER)
               good = (b == version);
            else if (p == POS_TYPE)
               msg_type = b;
            else if (p >= POS_LEN_LO && p <= POS_LEN_HI)
               msg_len[8*(p - POS_LEN_LO) +: 8] = b;
            else if (p >= SEQ_FIRST && p <= SEQ_LAST)
               msg_seq[8*(p - SEQ_FIRST) +: 8] = b;
            else if (p >= TS_FIRST && p <= HDR_LAST) begin
               msg_stamp[8*(p - TS_FIRST) +: 8] = b;
               if (p == HDR_LAST) begin
                  if (msg_len > length - MIN_FRAME || msg_len > PAYLOAD_LIMIT) begin
                     good = 1'b0;
                  end else begin
                     remaining = msg_len;
                     queue_result(KIND_HEADER, 8'h00, remaining == 0);
                  end
               end
            end else if (p > HDR_LAST && remaining > 0) begin
               queue_result(KIND_PAYLOAD, b, remaining == 1);
               remaining--;
            end
         end

         position = (p < POS_MAX) ? p + 12'd1 : POS_MAX;
      endfunction

      function void compare_item(rsp_type got);
         rsp_type want;
         if (deframed_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: item with none pending: kind %0d type %02h size %0d last %0b",
                        got.kind, got.proto_type, got.payload_size, got.last);
            return;
         end
         want = deframed_queue.pop_front();
         if (got.kind !== want.kind || got.proto_type !== want.proto_type ||
             got.payload_size !== want.payload_size ||
             got.seq_num !== want.seq_num ||
             got.sender_timestamp !== want.sender_timestamp ||
             got.signal_strength !== want.signal_strength ||
             got.payload_byte !== want.payload_byte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: expected kind %0d type %02h size %0d seq %08h ts %016h",
                        want.kind, want.proto_type, want.payload_size,
                        want.seq_num, want.sender_timestamp,
                        " rssi %0d byte %02h last %0b", want.signal_strength,
                        want.payload_byte, want.last);
               $display("       actual   kind %0d type %02h size %0d seq %08h ts %016h",
                        got.kind, got.proto_type, got.payload_size,
                        got.seq_num, got.sender_timestamp,
                        " rssi %0d byte %02h last %0b", got.signal_strength,
                        got.payload_byte, got.last);
            end
         end
      endfunction
   endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives received frames byte by byte into the frame filter / deframer and
// checks every header, payload and truncation item against a predictor.
// ----------------------------------------------------------------------------
// Four phases, each with its own register setting and handshake pattern:
// reset values with no idling, random values with an idle sender, all zeros
// with a stalling receiver, all ones with both. Phase one opens with directed
// frames (field extremes, each reject reason, both restart cases), then every
// phase sends random frames, mostly well formed with random content, the rest
// cut, broken or noise.
// ----------------------------------------------------------------------------
module testbench;
   import wffd_pkg::*;
   import deframer_scoreboard_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata  = '0;   // [7:0] byte, [19:8] length, [27:20] rssi
   logic [1:0]    req_tuser  = '0;   // [0] frame_start, [1] is_data_frame
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;         // type, size, seq, timestamp, rssi, byte
   logic [1:0]    rsp_tuser;         // [1:0] result_kind
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index  = '0;
   logic [47:0]   csr_data   = '0;

   deframer_scoreboard board;

   // register values the frame builder uses for well-formed headers
   logic [47:0]   cfg_bssid   = BSSID_RESET;
   logic [31:0]   cfg_magic   = MAGIC_RESET;
   logic [7:0]    cfg_version = VERSION_RESET;

   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   bit            hold_off_request = 1'b0;
   int            bytes_sent = 0;

   logic [7:0]    frame_buf [0:4199];

   wireless_frame_filter_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Receiver: random stalls per phase; on request one long hold-off so the
   // result register fills and the block has to stall its input.
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < 300) begin
               @(posedge clock);
               held++;
            end
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Monitor: all three channels sampled at the edge, results before inputs
   // since a result can only come from a byte taken at an earlier edge.
   always @(posedge clock) begin : monitor
      rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) begin
            got.kind             = result_kind_type'(rsp_tuser);
            got.proto_type       = rsp_tdata[7:0];
            got.payload_size     = rsp_tdata[17:8];
            got.seq_num          = rsp_tdata[49:18];
            got.sender_timestamp = rsp_tdata[113:50];
            got.signal_strength  = rsp_tdata[121:114];
            got.payload_byte     = rsp_tdata[129:122];
            got.last             = rsp_tlast;
            board.compare_item(got);
         end
         if (req_tvalid && req_tready)
            board.deframe_byte(req_tdata[7:0], req_tuser[0], req_tdata[19:8],
                               req_tdata[27:20], req_tuser[1]);
      end
   end

   // One byte item; tvalid stays up between back-to-back items.
   task automatic put_byte(input logic [7:0] b, input bit start, input logic [11:0] flen,
                           input logic [7:0] rssi, input bit data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, rssi, flen, b};
      req_tuser  <= {data, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send frame_buf[0..count-1]; length, rssi and data flag only mean
   // something on the start byte, so the rest carry random values.
   task automatic send_frame(input int count, input logic [11:0] flen, input logic [7:0] rssi,
                             input bit data, input bit with_start);
      for (int i = 0; i < count; i++) begin
         if (i == 0)
            put_byte(frame_buf[0], with_start, flen, rssi, data);
         else
            put_byte(frame_buf[i], 1'b0, $urandom_range(0, 4095), $urandom_range(0, 255),
                     $urandom_range(0, 1));
      end
   endtask

   // Random bytes up to total, then a header that passes the current registers.
   function automatic void build_header(input logic [7:0] mtype, input logic [15:0] plen,
                                        input logic [31:0] seq, input logic [63:0] stamp,
                                        input int total);
      for (int i = 0; i < total; i++)
         frame_buf[i] = $urandom_range(0, 255);
      frame_buf[POS_FC0] = FC0_BYTE;
      frame_buf[POS_FC1] = FC1_BYTE;
      for (int i = 0; i < 6; i++) begin
         frame_buf[DEST_FIRST + i]  = BCAST_BYTE;
         frame_buf[BSSID_FIRST + i] = cfg_bssid[8*(5-i) +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         frame_buf[MAGIC_FIRST + i] = cfg_magic[8*(3-i) +: 8];
         frame_buf[SEQ_FIRST + i]   = seq[8*i +: 8];
      end
      frame_buf[POS_VER]    = cfg_version;
      frame_buf[POS_TYPE]   = mtype;
      frame_buf[POS_LEN_LO] = plen[7:0];
      frame_buf[POS_LEN_HI] = plen[15:8];
      for (int i = 0; i < 8; i++)
         frame_buf[TS_FIRST + i] = stamp[8*i +: 8];
   endfunction

   // A byte position inside one of the checked header fields.
   function automatic int checked_spot(input int which);
      case (which)
         0:       return POS_FC0;
         1:       return POS_FC1;
         2:       return DEST_FIRST + $urandom_range(0, 5);
         3:       return BSSID_FIRST + $urandom_range(0, 5);
         4:       return MAGIC_FIRST + $urandom_range(0, 3);
         default: return POS_VER;
      endcase
   endfunction

   task automatic csr_put(input logic [1:0] index, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_config(input logic [47:0] b, input logic [31:0] m, input logic [7:0] v);
      cfg_bssid   = b;
      cfg_magic   = m;
      cfg_version = v;
      csr_put(CSR_BSSID, b);
      csr_put(CSR_MAGIC, {16'h0, m});
      csr_put(CSR_VERSION, {40'h0, v});
      csr_valid <= 1'b0;
   endtask

   // Wait for every pending item, then let bytes still in flight settle.
   task automatic wait_drained();
      int guard;
      guard = 0;
      @(posedge clock);
      while (board.deframed_queue.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic directed_frames();
      int spot;
      // bytes with no frame started yet: ignored even though they look valid
      build_header(8'h11, 16'd0, $urandom, {$urandom, $urandom}, 48);
      send_frame(48, 12'd48, 8'h00, 1'b1, 1'b0);
      // empty payload, shortest frame, weakest signal, zero fields
      build_header(8'h00, 16'd0, 32'h0, 64'h0, 48);
      send_frame(48, 12'd48, 8'h80, 1'b1, 1'b1);
      // largest payload, longest frame, strongest signal, all-ones fields;
      // the receiver holds off meanwhile
      hold_off_request = 1'b1;
      build_header(8'hff, PAYLOAD_LIMIT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
                   HDR_LAST + 1 + PAYLOAD_LIMIT + 4);
      send_frame(HDR_LAST + 1 + PAYLOAD_LIMIT + 4, 12'd4095, 8'h7f, 1'b1, 1'b1);
      // payload exactly fills the frame
      build_header($urandom, 16'd3, $urandom, {$urandom, $urandom}, 51);
      send_frame(51, 12'd51, $urandom_range(0, 255), 1'b1, 1'b1);
      // payload one past the frame
      build_header($urandom, 16'd4, $urandom, {$urandom, $urandom}, 51);
      send_frame(51, 12'd51, $urandom_range(0, 255), 1'b1, 1'b1);
      // payload one past the maximum
      build_header($urandom, PAYLOAD_LIMIT + 1, $urandom, {$urandom, $urandom}, 60);
      send_frame(60, 12'd4095, $urandom_range(0, 255), 1'b1, 1'b1);
      // not a data frame
      build_header($urandom, 16'd2, $urandom, {$urandom, $urandom}, 52);
      send_frame(52, 12'd52, $urandom_range(0, 255), 1'b0, 1'b1);
      // frame too short
      build_header($urandom, 16'd0, $urandom, {$urandom, $urandom}, 48);
      send_frame(48, 12'd47, $urandom_range(0, 255), 1'b1, 1'b1);
      // each checked header field wrong once
      for (int k = 0; k < 6; k++) begin
         build_header($urandom, 16'd1, $urandom, {$urandom, $urandom}, 49);
         spot = checked_spot(k);
         frame_buf[spot] = frame_buf[spot] ^ $urandom_range(1, 255);
         send_frame(49, 12'd49, $urandom_range(0, 255), 1'b1, 1'b1);
      end
      // early restart in the middle of a payload, then right after a header
      build_header($urandom, 16'd10, $urandom, {$urandom, $urandom}, 47);
      send_frame(47, 12'd58, $urandom_range(0, 255), 1'b1, 1'b1);
      build_header($urandom, 16'd5, $urandom, {$urandom, $urandom}, 44);
      send_frame(44, 12'd53, $urandom_range(0, 255), 1'b1, 1'b1);
      // restart one byte before the header completes: silent
      build_header($urandom, 16'd0, $urandom, {$urandom, $urandom}, HDR_LAST);
      send_frame(HDR_LAST, 12'd48, $urandom_range(0, 255), 1'b1, 1'b1);
   endtask

   task automatic random_frame();
      int pick, flen, count, spot, slack;
      logic [15:0] plen;
      bit data, with_start;
      pick  = $urandom_range(0, 99);
      plen  = ($urandom_range(0, 39) == 0) ? $urandom_range(0, PAYLOAD_LIMIT)
                                           : $urandom_range(0, 24);
      slack = $urandom_range(0, 4);
      flen  = MIN_FRAME + plen + slack;
      count = flen;
      data  = 1'b1;
      with_start = 1'b1;
      spot  = -1;
      if (pick < 55) begin
         // whole well-formed frame, FCS and slack included
      end else if (pick < 65) begin
         // cut inside the payload; the next start truncates it
         if (plen == 0) begin
            plen = 1;
            flen = flen + 1;
         end
         count = HDR_LAST + 1 + $urandom_range(0, plen - 1);
      end else if (pick < 72) begin
         count = $urandom_range(1, HDR_LAST);
      end else if (pick < 85) begin
         spot = checked_spot($urandom_range(0, 5));
      end else if (pick < 93) begin
         case ($urandom_range(0, 3))
            0: data = 1'b0;
            1: flen = $urandom_range(0, MIN_FRAME - 1);
            2: plen = flen - MIN_FRAME + $urandom_range(1, 8);
            default: begin
               plen  = $urandom_range(PAYLOAD_LIMIT + 1, 65535);
               flen  = 4095;
               count = HDR_LAST + 1 + $urandom_range(0, 16);
            end
         endcase
      end else begin
         // noise, sometimes continuing whatever frame came before
         count = $urandom_range(1, 60);
         flen  = $urandom_range(0, 4095);
         data  = $urandom_range(0, 1);
         with_start = ($urandom_range(0, 4) != 0);
      end
      build_header($urandom, plen, $urandom, {$urandom, $urandom}, count);
      if (pick >= 93)
         for (int i = 0; i < count; i++) frame_buf[i] = $urandom_range(0, 255);
      if (spot >= 0)
         frame_buf[spot] = frame_buf[spot] ^ $urandom_range(1, 255);
      send_frame(count, flen, $urandom_range(0, 255), data, with_start);
   endtask

   initial begin : stimulus
      int target;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_config({$urandom, $urandom}, $urandom, $urandom);
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               write_config(48'h0, 32'h0, 8'h00);
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               write_config(48'hffff_ffff_ffff, 32'hffff_ffff, 8'hff);
               send_idle_pct  = 36;
               recv_stall_pct = 36;
            end
         endcase
         if (phase == 0)
            directed_frames();
         target = bytes_sent + 100;
         while (bytes_sent < target)
            random_frame();
         req_tvalid <= 1'b0;
         wait_drained();
      end

      if (board.deframed_queue.size() != 0) begin
         $display("ERROR: %0d items never arrived", board.deframed_queue.size());
         board.mismatches += board.deframed_queue.size();
      end
      $display("Summary: %0d bytes driven; %0d header, %0d payload, %0d truncation items",
               board.bytes_in, board.kind_count[KIND_HEADER], board.kind_count[KIND_PAYLOAD],
               board.kind_count[KIND_TRUNC]);
      $display("Summary: 4 register settings, 4 handshake patterns, %0d mismatches",
               board.mismatches);
      if (board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/wffd_pkg.sv
rtl/wffd_hdr_match.sv
rtl/wffd_rsp_reg.sv
rtl/wireless_frame_filter_deframer_core.sv
verif/deframer_scoreboard_pkg.sv
verif/testbench.sv
